>>> src/isqbs_pkg.sv
// Package for the integer square root binary search unit.
// Holds field widths, controller state type and control/status structs.
package isqbs_pkg;

   // Fixed payload widths
   localparam int VALUE_W = 32;
   localparam int ROOT_W  = 16;
   localparam int TRIES_W = 6;

   // Controller states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;     // take a new operand, set up bounds
      logic step;     // one search iteration
      logic capture;  // write result into the output registers
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic finish;   // search over: exact hit or midpoint not above lower bound
   } sts_type;

endpackage

>>> src/isqbs_datapath.sv
// Datapath of the square root search: bounds, midpoint, squaring compare,
// try counter and result registers. Depends on isqbs_pkg.
module isqbs_datapath #(
   parameter int OPERAND_BITS = 32
) (
   input  logic                          clock,
   input  logic [isqbs_pkg::VALUE_W-1:0] value_in,
   input  isqbs_pkg::cmd_type            cmd,
   output isqbs_pkg::sts_type            sts,
   output logic [isqbs_pkg::ROOT_W-1:0]  root_out,
   output logic [isqbs_pkg::TRIES_W-1:0] tries_out
);
   import isqbs_pkg::*;

   localparam int N = OPERAND_BITS;
   localparam int H = (OPERAND_BITS + 1) / 2;   // midpoints below 2^H can be squared

   logic [N-1:0]       operand;
   logic [N-1:0]       n_ff, n_in;
   logic [N-1:0]       lower_ff, lower_in;
   logic [N-1:0]       upper_ff, upper_in;
   logic [N-1:0]       mid_ff, mid_in;
   logic [TRIES_W-1:0] tries_ff, tries_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [TRIES_W-1:0] tries_out_ff, tries_out_in;

   logic [N:0]         sum_init, sum_lo, sum_hi;
   logic [N-1:0]       mid_lo_half, mid_hi_half;
   logic               mid_big;
   logic [2*H-1:0]     square, n_ext;
   logic               sq_gt, sq_eq, cont_now, cont_lo, cont_hi;
   logic [N-1:0]       root_sel;
   logic [ROOT_W-1:0]  root_fit;

   // Operand sized to the search width
   generate
      if (N <= VALUE_W) begin : g_narrow
         assign operand = value_in[N-1:0];
      end else begin : g_wide
         assign operand = {{(N-VALUE_W){1'b0}}, value_in};
      end
   endgenerate

   // Square compare: a midpoint with any bit at or above H squares past n
   assign mid_big = |mid_ff[N-1:H];
   assign square  = mid_ff[H-1:0] * mid_ff[H-1:0];
   assign n_ext   = (2*H)'(n_ff);
   assign sq_gt   = mid_big || (square > n_ext);
   assign sq_eq   = !mid_big && (square == n_ext);

   // Both candidate next midpoints, computed beside the multiply
   assign sum_init    = (N+1)'(operand) + (N+1)'(1);
   assign sum_lo      = (N+1)'(lower_ff) + (N+1)'(mid_ff);
   assign sum_hi      = (N+1)'(mid_ff) + (N+1)'(upper_ff);
   assign mid_lo_half = sum_lo[N:1];
   assign mid_hi_half = sum_hi[N:1];
   assign cont_now    = mid_ff > lower_ff;
   assign cont_lo     = mid_lo_half > lower_ff;
   assign cont_hi     = mid_hi_half > mid_ff;

   assign sts.finish = !cont_now || sq_eq;

   // Result: exact midpoint, else lower bound
   assign root_sel = (cont_now && sq_eq) ? mid_ff : lower_ff;
   generate
      if (N >= ROOT_W) begin : g_root_trunc
         assign root_fit = root_sel[ROOT_W-1:0];
      end else begin : g_root_ext
         assign root_fit = {{(ROOT_W-N){1'b0}}, root_sel};
      end
   endgenerate

   // Next state of search registers
   always_comb begin
      n_in         = n_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      mid_in       = mid_ff;
      tries_in     = tries_ff;
      root_in      = root_ff;
      tries_out_in = tries_out_ff;
      if (cmd.load) begin
         n_in     = operand;
         // zero operand: lower bound 0 makes the search end at once with 0
         lower_in = (operand == '0) ? '0 : N'(1);
         upper_in = operand;
         mid_in   = sum_init[N:1];
         tries_in = TRIES_W'(1);
      end else if (cmd.step) begin
         if (sq_gt) begin
            upper_in = mid_ff;
            mid_in   = mid_lo_half;
            tries_in = tries_ff + TRIES_W'(cont_lo);
         end else begin
            lower_in = mid_ff;
            mid_in   = mid_hi_half;
            tries_in = tries_ff + TRIES_W'(cont_hi);
         end
      end
      if (cmd.capture) begin
         root_in      = root_fit;
         tries_out_in = tries_ff;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      lower_ff     <= lower_in;
      upper_ff     <= upper_in;
      mid_ff       <= mid_in;
      tries_ff     <= tries_in;
      root_ff      <= root_in;
      tries_out_ff <= tries_out_in;
   end

   assign root_out  = root_ff;
   assign tries_out = tries_out_ff;

endmodule

>>> src/isqbs_ctrl.sv
// Controller of the square root search: sequences load, steps and result
// capture, and owns both handshakes. Depends on isqbs_pkg.
module isqbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  isqbs_pkg::sts_type sts,
   output isqbs_pkg::cmd_type cmd
);
   import isqbs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output register can take a result if empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.finish) begin
               if (out_free) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.capture || (rsp_valid_ff && !rsp_ready);
   end

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/integer_sqrt_binary_search_unit.sv
// Integer square root by binary search; top level joining controller and datapath.
// The controller takes an operand in idle, then runs one iteration (square, compare, bound
// update) per cycle; when the search ends it captures the result once the output register
// is free. A new operand is taken only in idle, so one search ends before the next begins.
// Reset: synchronous active high; clears controller state and result valid.
module integer_sqrt_binary_search_unit #(
   parameter int OPERAND_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [isqbs_pkg::VALUE_W-1:0] req_value_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [isqbs_pkg::ROOT_W-1:0]  rsp_root_out,
   output logic [isqbs_pkg::TRIES_W-1:0] rsp_tries_out
);
   import isqbs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   isqbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Search datapath
   isqbs_datapath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_datapath (
      .clock     (clock),
      .value_in  (req_value_in),
      .cmd       (cmd),
      .sts       (sts),
      .root_out  (rsp_root_out),
      .tries_out (rsp_tries_out)
   );

endmodule

>>> verif/integer_sqrt_binary_search_unit_test.sv
// Self-checking testbench for integer_sqrt_binary_search_unit: directed operands, then random ones.
// Uses isqbs_pkg for field widths; results are checked against a binary-search root predictor.
module integer_sqrt_binary_search_unit_test;
   import isqbs_pkg::*;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 1950;
   localparam int CALM_TAIL     = 250;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic [ROOT_W-1:0]  root;
      logic [TRIES_W-1:0] tries;
   } sqrt_result_type;

   // One directed row: operand, plus a typed-in answer where it is obvious
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               known;
      logic [ROOT_W-1:0]  root;
      logic [TRIES_W-1:0] tries;
   } op_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [VALUE_W-1:0]   req_value_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ROOT_W-1:0]    rsp_root_out;
   logic [TRIES_W-1:0]   rsp_tries_out;

   sqrt_result_type pending_roots[$];
   op_row_type      directed_rows [DIRECTED_ROWS];
   int              error_count = 0;
   int              checked_count = 0;
   int              exact_squares = 0;
   int              deepest_search = 0;
   bit              idle_enabled = 1'b1;

   integer_sqrt_binary_search_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_root_out  (rsp_root_out),
      .rsp_tries_out (rsp_tries_out)
   );

   // Floor square root by binary search, counting the midpoints tried
   function automatic sqrt_result_type isqrt_search(logic [VALUE_W-1:0] value);
      logic [63:0]        n;
      logic [63:0]        lo;
      logic [63:0]        hi;
      logic [63:0]        mid;
      logic [63:0]        sq;
      logic [63:0]        root;
      logic [TRIES_W-1:0] tries;
      bit                 hit;
      sqrt_result_type    res;
      n     = {32'd0, value};
      tries = 1;
      if (n == 0) begin
         res.root  = '0;
         res.tries = tries;
         return res;
      end
      lo   = 1;
      hi   = n;
      hit  = 1'b0;
      mid  = lo + (hi - lo) / 2;
      root = lo;
      while (mid > lo && !hit) begin
         sq = mid * mid;
         if (sq == n) begin
            root = mid;
            hit  = 1'b1;
         end else begin
            if (sq > n)
               hi = mid;
            else
               lo = mid;
            mid = lo + (hi - lo) / 2;
            if (mid > lo)
               tries++;
         end
      end
      if (!hit)
         root = lo;
      res.root  = root[ROOT_W-1:0];
      res.tries = tries;
      return res;
   endfunction

   // Random operand: full range, squares and their neighbors, small and narrow values
   function automatic logic [VALUE_W-1:0] pick_operand();
      logic [VALUE_W-1:0] s;
      s = $urandom_range(1, 65535);
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4:    return s * s;
         5:       return s * s - 1;
         6:       return s * s + 2 * s;
         7:       return $urandom_range(0, 300);
         8:       return $urandom >> $urandom_range(0, 31);
         default: return s * s + 1;
      endcase
   endfunction

   // Present one operand, with an occasional gap first, and wait for it to be taken
   task automatic send_operand(input logic [VALUE_W-1:0] value, input sqrt_result_type want);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_value_in <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_roots.push_back(want);
      if ({16'd0, want.root} * {16'd0, want.root} == value)
         exact_squares++;
      if (want.tries > deepest_search)
         deepest_search = want.tries;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop
   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   // Result side: ready with random stall bursts
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: compare each accepted item with the oldest expectation
   always @(posedge clock) begin
      sqrt_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_roots.size() == 0) begin
            $error("unexpected result: root_out %0d, tries_out %0d", rsp_root_out,
                   rsp_tries_out);
            error_count++;
         end else begin
            want = pending_roots.pop_front();
            checked_count++;
            if (rsp_root_out !== want.root) begin
               $error("root_out: expected %0d, got %0d", want.root, rsp_root_out);
               error_count++;
            end
            if (rsp_tries_out !== want.tries) begin
               $error("tries_out: expected %0d, got %0d", want.tries, rsp_tries_out);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      sqrt_result_type want;
      logic [VALUE_W-1:0] value;
      int guard;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_value_in <= '0;
      // zero, one to three: obvious; everything else from the predictor
      directed_rows = '{
         '{32'd0,          1'b1, 16'd0, 6'd1},
         '{32'd1,          1'b1, 16'd1, 6'd1},
         '{32'd2,          1'b1, 16'd1, 6'd1},
         '{32'd3,          1'b1, 16'd1, 6'd1},
         '{32'd4,          1'b0, 16'd0, 6'd0},
         '{32'd5,          1'b0, 16'd0, 6'd0},
         '{32'd8,          1'b0, 16'd0, 6'd0},
         '{32'd9,          1'b0, 16'd0, 6'd0},
         '{32'd15,         1'b0, 16'd0, 6'd0},
         '{32'd16,         1'b0, 16'd0, 6'd0},
         '{32'd24,         1'b0, 16'd0, 6'd0},
         '{32'd25,         1'b0, 16'd0, 6'd0},
         '{32'd99,         1'b0, 16'd0, 6'd0},
         '{32'd100,        1'b0, 16'd0, 6'd0},
         '{32'h0000_FFFF,  1'b0, 16'd0, 6'd0},
         '{32'h0001_0000,  1'b0, 16'd0, 6'd0},
         '{32'h7FFF_FFFF,  1'b0, 16'd0, 6'd0},
         '{32'h8000_0000,  1'b0, 16'd0, 6'd0},
         '{32'h5555_5555,  1'b0, 16'd0, 6'd0},
         '{32'hAAAA_AAAA,  1'b0, 16'd0, 6'd0},
         '{32'hFFFE_0000,  1'b0, 16'd0, 6'd0},
         '{32'hFFFE_0001,  1'b0, 16'd0, 6'd0},
         '{32'hFFFF_FFFE,  1'b0, 16'd0, 6'd0},
         '{32'hFFFF_FFFF,  1'b0, 16'd0, 6'd0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].known) begin
            want.root  = directed_rows[i].root;
            want.tries = directed_rows[i].tries;
         end else begin
            want = isqrt_search(directed_rows[i].value);
         end
         send_operand(directed_rows[i].value, want);
      end

      // random operands; calm windows now and then, and calm throughout the tail
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0)
            idle_enabled = ($urandom_range(0, 3) != 0);
         if (i >= RANDOM_ITEMS - CALM_TAIL)
            idle_enabled = 1'b0;
         value = pick_operand();
         send_operand(value, isqrt_search(value));
      end
      req_valid <= 1'b0;

      // drain
      guard = 0;
      while (pending_roots.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_roots.size() != 0) begin
         $error("%0d expected results never arrived", pending_roots.size());
         error_count++;
      end

      $display("Ran %0d table operands and %0d random operands, %0d results compared.",
               DIRECTED_ROWS, RANDOM_ITEMS, checked_count);
      $display("Operands that were perfect squares: %0d; longest search: %0d midpoints.",
               exact_squares, deepest_search);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
src/isqbs_pkg.sv
src/isqbs_datapath.sv
src/isqbs_ctrl.sv
src/integer_sqrt_binary_search_unit.sv
verif/integer_sqrt_binary_search_unit_test.sv
